@@ rtl/cpoc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpoc_pkg
// Shared operation codes, status codes and the item record that travels
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package cpoc_pkg;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_ADD    = 2'd1,
		OP_SAMPLE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_RANGE  = 2'd1,
		ST_FULL   = 2'd2,
		ST_BEYOND = 2'd3
	} status_t;

	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef struct packed {
		logic               kind;
		status_t            status;
		logic signed [31:0] value;
		logic [63:0]        stamp;
		logic [7:0]         flag;
		logic [23:0]        number;
	} item_t;

endpackage

@@ rtl/change_point_offset_correction.sv @@
// ----------------------------------------------------------------------------
// change_point_offset_correction
// Removes level shifts from a series of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Usage: items enter through push/full and each produces exactly one result,
// read through empty/pop in the order the items were taken. A start item sets
// the series length and clears the change-point table and sample counter; an
// add item stores a change point if in range and the table has room; a
// sample item in range returns the sample minus the sum of the shifts of all
// points at or before its position, saturated. Throughput is one transaction
// per cycle while full is low. Each item passes through the registered adder
// tree that sums the table's matching shifts, then the queue and the output
// register. Items sit in a queue sized to cover the tree, so the front keeps
// accepting while the receiver stalls; full rises only once that queue and
// the tree together hold as many items as the queue can take. Results are
// held unchanged until popped. Reset empties the pipeline and queue, and
// clears the series length, point count and sample counter; table entries
// need no clearing because only entries below the count are ever used.
// ----------------------------------------------------------------------------
module change_point_offset_correction import cpoc_pkg::*; #(
	parameter int MAX_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic [23:0]        series_length,
	input  logic [23:0]        point_index,
	input  logic signed [31:0] point_shift,
	input  logic signed [31:0] sample_value,
	input  logic [63:0]        sample_time,
	input  logic [7:0]         sample_flag,
	output logic               empty,
	input  logic               pop,
	output logic               result_kind,
	output logic [1:0]         status,
	output logic signed [31:0] adjusted_value,
	output logic [63:0]        time_out,
	output logic [7:0]         flag_out,
	output logic [23:0]        sample_number
);

	localparam int NLEV   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 0;
	localparam int SUM_W  = 32 + NLEV;
	localparam int QDEPTH = NLEV + 3;
	localparam int QW     = $bits(item_t) + SUM_W;

	logic                    fq_push;
	item_t                   fq_item;
	logic signed [SUM_W-1:0] fq_corr;
	logic                    qb_pop;
	logic                    qb_nonempty;
	logic [QW-1:0]           qb_data;
	item_t                   qb_item;
	logic signed [SUM_W-1:0] qb_corr;
	item_t                   res;

	cpoc_front #(
		.MAX_POINTS (MAX_POINTS),
		.QDEPTH     (QDEPTH),
		.SUM_W      (SUM_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.series_length (series_length),
		.point_index   (point_index),
		.point_shift   (point_shift),
		.sample_value  (sample_value),
		.sample_time   (sample_time),
		.sample_flag   (sample_flag),
		.q_push        (fq_push),
		.q_item        (fq_item),
		.q_corr        (fq_corr),
		.q_pop         (qb_pop)
	);

	cpoc_queue #(
		.WIDTH (QW),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fq_push),
		.wdata    ({fq_item, fq_corr}),
		.pop      (qb_pop),
		.rdata    (qb_data),
		.nonempty (qb_nonempty)
	);

	assign qb_item = qb_data[QW-1:SUM_W];
	assign qb_corr = qb_data[SUM_W-1:0];

	cpoc_back #(
		.SUM_W (SUM_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (qb_nonempty),
		.q_item     (qb_item),
		.q_corr     (qb_corr),
		.q_pop      (qb_pop),
		.pop        (pop),
		.empty      (empty),
		.res        (res)
	);

	assign result_kind    = res.kind;
	assign status         = res.status;
	assign adjusted_value = res.value;
	assign time_out       = res.stamp;
	assign flag_out       = res.flag;
	assign sample_number  = res.number;

endmodule

@@ rtl/cpoc_front.sv @@
// ----------------------------------------------------------------------------
// cpoc_front
// Accepts items, keeps the series state and the change-point table, and
// sums the applicable shifts of each sample through a registered adder tree.
// ----------------------------------------------------------------------------
module cpoc_front import cpoc_pkg::*; #(
	parameter int MAX_POINTS = 16,
	parameter int QDEPTH     = 8,
	parameter int SUM_W      = 36
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [1:0]              operation,
	input  logic [23:0]             series_length,
	input  logic [23:0]             point_index,
	input  logic signed [31:0]      point_shift,
	input  logic signed [31:0]      sample_value,
	input  logic [63:0]             sample_time,
	input  logic [7:0]              sample_flag,
	output logic                    q_push,
	output item_t                   q_item,
	output logic signed [SUM_W-1:0] q_corr,
	input  logic                    q_pop
);

	localparam int NLEV  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 0;
	localparam int P2    = 1 << NLEV;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int USE_W = $clog2(QDEPTH + 1);

	logic [23:0]        idx_tab_q   [0:MAX_POINTS-1];
	logic signed [31:0] shift_tab_q [0:MAX_POINTS-1];
	logic [CNT_W-1:0]   count_q;
	logic [23:0]        length_q;
	logic [23:0]        counter_q;
	logic [USE_W-1:0]   used_q;

	logic  accept;
	logic  sample_ok;
	item_t item;
	logic [MAX_POINTS-1:0] hit;

	logic signed [SUM_W-1:0] tree_q [0:NLEV][0:P2-1];
	logic                    vld_q  [0:NLEV];
	item_t                   meta_q [0:NLEV];

	assign full   = (used_q == USE_W'(QDEPTH));
	assign accept = push && !full;

	// Classify the incoming item against the current state.
	always_comb begin
		item      = '0;
		item.kind = KIND_ACK;
		item.status = ST_OK;
		sample_ok = 1'b0;
		case (operation)
			OP_START: begin
				item.status = ST_OK;
			end
			OP_ADD: begin
				if (point_index >= length_q) begin
					item.status = ST_RANGE;
				end else if (count_q == CNT_W'(MAX_POINTS)) begin
					item.status = ST_FULL;
				end
			end
			OP_SAMPLE: begin
				item.kind   = KIND_SAMPLE;
				item.stamp  = sample_time;
				item.flag   = sample_flag;
				item.number = counter_q;
				if (counter_q >= length_q) begin
					item.status = ST_BEYOND;
				end else begin
					item.value = sample_value;
					sample_ok  = 1'b1;
				end
			end
			default: begin
				item.status = ST_OK;
			end
		endcase
	end

	// All table entries are compared against the sample number at once.
	always_comb begin
		for (int k = 0; k < MAX_POINTS; k++) begin
			hit[k] = sample_ok && (CNT_W'(k) < count_q) && (idx_tab_q[k] <= counter_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			length_q  <= '0;
			counter_q <= '0;
		end else if (accept) begin
			case (operation)
				OP_START: begin
					length_q  <= series_length;
					count_q   <= '0;
					counter_q <= '0;
				end
				OP_ADD: begin
					if (item.status == ST_OK) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_SAMPLE: begin
					if (sample_ok) begin
						counter_q <= counter_q + 24'd1;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && operation == OP_ADD && item.status == ST_OK) begin
			idx_tab_q[count_q[IDX_W-1:0]]   <= point_index;
			shift_tab_q[count_q[IDX_W-1:0]] <= point_shift;
		end
	end

	// Items accepted but not yet taken out of the queue by the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			case ({accept, q_pop})
				2'b10:   used_q <= used_q + USE_W'(1);
				2'b01:   used_q <= used_q - USE_W'(1);
				default: used_q <= used_q;
			endcase
		end
	end

	// Leaf level of the adder tree.
	always_ff @(posedge clk) begin
		meta_q[0] <= item;
		for (int k = 0; k < P2; k++) begin
			if (k < MAX_POINTS && hit[k % MAX_POINTS]) begin
				tree_q[0][k] <= SUM_W'(shift_tab_q[k % MAX_POINTS]);
			end else begin
				tree_q[0][k] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else begin
			vld_q[0] <= accept;
		end
	end

	for (genvar l = 1; l <= NLEV; l++) begin : g_lev
		always_ff @(posedge clk) begin
			meta_q[l] <= meta_q[l-1];
			for (int n = 0; n < P2; n++) begin
				if (n < (P2 >> l)) begin
					tree_q[l][n] <= tree_q[l-1][(2*n) % P2] + tree_q[l-1][(2*n+1) % P2];
				end else begin
					tree_q[l][n] <= '0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[l] <= 1'b0;
			end else begin
				vld_q[l] <= vld_q[l-1];
			end
		end
	end

	assign q_push = vld_q[NLEV];
	assign q_item = meta_q[NLEV];
	assign q_corr = tree_q[NLEV][0];

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USE_W'(QDEPTH))
		else $error("More transactions in flight than the queue can hold.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("Change-point count exceeds the table size.");

	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		counter_q <= length_q)
		else $error("Sample counter ran past the series length.");

endmodule

@@ rtl/cpoc_queue.sv @@
// ----------------------------------------------------------------------------
// cpoc_queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module cpoc_queue import cpoc_pkg::*; #(
	parameter int WIDTH = 167,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             nonempty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;

	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == CW'(DEPTH)))
		else $error("Queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && count_q == '0))
		else $error("Queue read while empty.");

endmodule

@@ rtl/cpoc_back.sv @@
// ----------------------------------------------------------------------------
// cpoc_back
// Subtracts the summed correction from the sample, saturates the result to
// signed Q16.16 and holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module cpoc_back import cpoc_pkg::*; #(
	parameter int SUM_W = 36
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_nonempty,
	input  item_t                   q_item,
	input  logic signed [SUM_W-1:0] q_corr,
	output logic                    q_pop,
	input  logic                    pop,
	output logic                    empty,
	output item_t                   res
);

	logic                  out_valid_q;
	item_t                 out_q;
	logic signed [SUM_W:0] diff;
	logic [SUM_W-31:0]     top_bits;
	item_t                 next;

	assign q_pop = q_nonempty && (!out_valid_q || pop);

	// Corrections of non-sample items are zero, as are their values.
	always_comb begin
		diff     = {{(SUM_W - 31){q_item.value[31]}}, q_item.value} - {q_corr[SUM_W-1], q_corr};
		top_bits = diff[SUM_W:31];
		next     = q_item;
		if (top_bits == '0 || top_bits == '1) begin
			next.value = diff[31:0];
		end else if (diff[SUM_W]) begin
			next.value = 32'sh8000_0000;
		end else begin
			next.value = 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= next;
		end
	end

	assign empty = !out_valid_q;
	assign res   = out_q;

endmodule
